FILE: rtl/kint_pkg.sv
package kint_pkg;

  // Width of the stream offset counter and saturation point of token lengths.
  localparam int POS_WIDTH = 16;
  localparam int LEN_MAX = 255;

  // The length counter is at least as wide as the length port.
  localparam int CNT_W = ($clog2(LEN_MAX + 1) > 8) ? $clog2(LEN_MAX + 1) : 8;
  localparam int POS_EXT = (POS_WIDTH > 16) ? POS_WIDTH : 16;

  // Queue between the scanner and the output stage.
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);

  typedef enum logic [4:0] {
    KIND_EOI    = 5'd0,
    KIND_SEMI   = 5'd1,
    KIND_PLUS   = 5'd2,
    KIND_MINUS  = 5'd3,
    KIND_TIMES  = 5'd4,
    KIND_DIV    = 5'd5,
    KIND_LPAREN = 5'd6,
    KIND_RPAREN = 5'd7,
    KIND_LBRACE = 5'd8,
    KIND_RBRACE = 5'd9,
    KIND_EQ     = 5'd10,
    KIND_LT     = 5'd11,
    KIND_GT     = 5'd12,
    KIND_DO     = 5'd13,
    KIND_IF     = 5'd14,
    KIND_WHILE  = 5'd15,
    KIND_IDENT  = 5'd16,
    KIND_NUMBER = 5'd17,
    KIND_ERROR  = 5'd18
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_KEYWORD = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_ERROR   = 3'd4
  } mode_t;

  // Keyword progress codes: which keyword prefix has been seen so far.
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_D    = 3'd1;
  localparam logic [2:0] KW_I    = 3'd2;
  localparam logic [2:0] KW_W    = 3'd3;
  localparam logic [2:0] KW_WH   = 3'd4;
  localparam logic [2:0] KW_WHI  = 3'd5;
  localparam logic [2:0] KW_WHIL = 3'd6;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic        clipped;
  } tok_t;

  // One queue entry holds every token caused by one input byte.
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } step_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Single-character operators; KIND_EOI means the byte is no operator.
  function automatic kind_t op_kind(input logic [7:0] b);
    kind_t k;
    unique case (b)
      8'h3B:   k = KIND_SEMI;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_TIMES;
      8'h2F:   k = KIND_DIV;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h3D:   k = KIND_EQ;
      8'h3C:   k = KIND_LT;
      8'h3E:   k = KIND_GT;
      default: k = KIND_EOI;
    endcase
    return k;
  endfunction

  // Character that continues the keyword prefix, zero where none does.
  function automatic logic [7:0] kw_next(input logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      KW_D:    c = 8'h6F;
      KW_I:    c = 8'h66;
      KW_W:    c = 8'h68;
      KW_WH:   c = 8'h69;
      KW_WHI:  c = 8'h6C;
      KW_WHIL: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Keyword completed by the next character; KIND_EOI where none is.
  function automatic kind_t kw_done(input logic [2:0] p);
    kind_t k;
    unique case (p)
      KW_D:    k = KIND_DO;
      KW_I:    k = KIND_IF;
      KW_WHIL: k = KIND_WHILE;
      default: k = KIND_EOI;
    endcase
    return k;
  endfunction

  // Low 16 bits of a stream offset.
  function automatic logic [15:0] to_start(input logic [POS_WIDTH-1:0] pos);
    logic [POS_EXT-1:0] ext;
    ext = POS_EXT'(pos);
    return ext[15:0];
  endfunction

endpackage

FILE: rtl/kint_scan.sv
module kint_scan
  import kint_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_req,
  output logic       push,
  output step_t      push_data
);

  mode_t                 mode, mode_next;
  logic [2:0]            kwp, kwp_next;
  logic [POS_WIDTH-1:0]  tbegin, tbegin_next;
  logic [CNT_W-1:0]      tcount, tcount_next;
  logic                  tclip, tclip_next;
  logic [POS_WIDTH-1:0]  offset, offset_next;

  logic                  fr_emit, fr_start, fr_eoi;
  mode_t                 fr_mode;
  logic [2:0]            fr_kwp;
  tok_t                  fr_tok;
  kind_t                 op;

  logic                  pend_v, use_fresh;
  tok_t                  pend_tok;
  logic [CNT_W-1:0]      tcount_inc;
  logic                  alnum;

  assign op         = op_kind(byte_req);
  assign alnum      = is_letter(byte_req) || is_digit(byte_req);
  assign tcount_inc = tcount + CNT_W'(1);

  // Handling of a byte that arrives between tokens.
  always_comb begin
    fr_tok   = '{kind: KIND_EOI, start: to_start(offset), length: 8'd1, clipped: 1'b0};
    fr_emit  = 1'b0;
    fr_start = 1'b0;
    fr_eoi   = 1'b0;
    fr_mode  = MODE_IDLE;
    fr_kwp   = kwp;
    if (byte_req == 8'h00) begin
      fr_emit = 1'b1;
      fr_eoi  = 1'b1;
    end else if (is_space(byte_req)) begin
      fr_emit = 1'b0;
    end else if (op != KIND_EOI) begin
      fr_emit     = 1'b1;
      fr_tok.kind = op;
    end else if ((byte_req == 8'h64) || (byte_req == 8'h69) || (byte_req == 8'h77)) begin
      fr_start = 1'b1;
      fr_mode  = MODE_KEYWORD;
      fr_kwp   = (byte_req == 8'h64) ? KW_D : (byte_req == 8'h69) ? KW_I : KW_W;
    end else if (is_letter(byte_req)) begin
      fr_start = 1'b1;
      fr_mode  = MODE_IDENT;
    end else if (is_digit(byte_req)) begin
      fr_start = 1'b1;
      fr_mode  = MODE_NUMBER;
    end else begin
      fr_emit     = 1'b1;
      fr_mode     = MODE_ERROR;
      fr_tok.kind = KIND_ERROR;
    end
  end

  // Scan state machine: next state and the pending token it closes.
  always_comb begin
    mode_next   = mode;
    kwp_next    = kwp;
    tbegin_next = tbegin;
    tcount_next = tcount;
    tclip_next  = tclip;
    offset_next = offset + POS_WIDTH'(1);
    pend_v      = 1'b0;
    use_fresh   = 1'b0;
    pend_tok    = '{kind: KIND_IDENT, start: to_start(tbegin), length: tcount[7:0],
                    clipped: tclip};
    unique case (mode)
      MODE_ERROR: begin
        if (byte_req == 8'h00) begin
          mode_next   = MODE_IDLE;
          offset_next = '0;
        end
      end
      MODE_KEYWORD: begin
        if ((byte_req != 8'h00) && (byte_req == kw_next(kwp))) begin
          if (kw_done(kwp) != KIND_EOI) begin
            pend_v           = 1'b1;
            pend_tok.kind    = kw_done(kwp);
            pend_tok.length  = tcount_inc[7:0];
            pend_tok.clipped = 1'b0;
            mode_next        = MODE_IDLE;
          end else begin
            kwp_next = kwp + 3'd1;
            if (tcount >= CNT_W'(LEN_MAX)) tclip_next = 1'b1;
            else tcount_next = tcount_inc;
          end
        end else if (alnum) begin
          mode_next = MODE_IDENT;
          if (tcount >= CNT_W'(LEN_MAX)) tclip_next = 1'b1;
          else tcount_next = tcount_inc;
        end else begin
          pend_v    = 1'b1;
          use_fresh = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (alnum) begin
          if (tcount >= CNT_W'(LEN_MAX)) tclip_next = 1'b1;
          else tcount_next = tcount_inc;
        end else begin
          pend_v    = 1'b1;
          use_fresh = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(byte_req)) begin
          if (tcount >= CNT_W'(LEN_MAX)) tclip_next = 1'b1;
          else tcount_next = tcount_inc;
        end else begin
          pend_v        = 1'b1;
          pend_tok.kind = KIND_NUMBER;
          use_fresh     = 1'b1;
        end
      end
      default: begin
        use_fresh = 1'b1;
      end
    endcase

    // The byte that ends a token, or arrives between tokens, is handled afresh.
    if (use_fresh) begin
      mode_next = fr_mode;
      kwp_next  = fr_kwp;
      if (fr_start) begin
        tbegin_next = offset;
        tcount_next = CNT_W'(1);
        tclip_next  = 1'b0;
      end
      if (fr_eoi) offset_next = '0;
    end
  end

  // Queue entry for this byte.
  always_comb begin
    push             = accept && (pend_v || (use_fresh && fr_emit));
    push_data.two    = pend_v && use_fresh && fr_emit;
    push_data.first  = pend_v ? pend_tok : fr_tok;
    push_data.second = fr_tok;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      kwp    <= KW_NONE;
      tbegin <= '0;
      tcount <= '0;
      tclip  <= 1'b0;
      offset <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      kwp    <= kwp_next;
      tbegin <= tbegin_next;
      tcount <= tcount_next;
      tclip  <= tclip_next;
      offset <= offset_next;
    end
  end

endmodule

FILE: rtl/kint_queue.sv
module kint_queue
  import kint_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  nonempty,
  output step_t head
);

  step_t             mem [QDEPTH];
  logic [QIDX_W-1:0] wptr, rptr;
  logic [QIDX_W:0]   count;

  assign full     = (count == (QIDX_W + 1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QIDX_W'(1);
      if (pop) rptr <= rptr + QIDX_W'(1);
      if (push && !pop) count <= count + (QIDX_W + 1)'(1);
      else if (pop && !push) count <= count - (QIDX_W + 1)'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

FILE: rtl/kint_emit.sv
module kint_emit
  import kint_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  step_t       q_data,
  output logic        q_pop,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [7:0]  token_length,
  output logic        length_clipped,
  output logic        last
);

  logic  cur_v;
  step_t cur;
  logic  second_sel;
  logic  done;
  tok_t  tok;

  // The held entry is finished when its final token is taken.
  assign done  = cur_v && !token_stall && (!cur.two || second_sel);
  assign q_pop = q_valid && (!cur_v || done);

  assign tok            = second_sel ? cur.second : cur.first;
  assign token_valid    = cur_v;
  assign token_kind     = tok.kind;
  assign token_start    = tok.start;
  assign token_length   = tok.length;
  assign length_clipped = tok.clipped;
  assign last           = !cur.two || second_sel;

  // Control of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v      <= 1'b0;
      second_sel <= 1'b0;
    end else if (q_pop) begin
      cur_v      <= 1'b1;
      second_sel <= 1'b0;
    end else if (done) begin
      cur_v <= 1'b0;
    end else if (cur_v && !token_stall) begin
      second_sel <= 1'b1;
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // The second token is only ever selected for an entry that has one.
  a_second_has_two: assert property (@(posedge clk) disable iff (rst)
    (cur_v && second_sel) |-> cur.two)
    else $error("second token selected for a single-token entry");

  // A transaction that is not the last of its byte is followed by the second token.
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (token_valid && !token_stall && !last) |=> (token_valid && second_sel))
    else $error("second token of a byte was not presented");

  // A freshly loaded entry starts with its first token.
  a_load_first: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (cur_v && !second_sel))
    else $error("loaded entry does not start at its first token");

endmodule

FILE: rtl/keyword_ident_number_tokenizer_top.sv
// The tokens of each accepted byte are written to the step queue as one entry, then
// loaded into the output register that drives the token ports.
// Throughput: one byte per cycle while the four-entry step queue has room; the output
// port gives one token per cycle while token_stall is low, so a byte that closes one
// token and is itself a token gives both there, one after the other. Reset clears the
// scanner to idle with offset zero and empties the queue and the output register.
module keyword_ident_number_tokenizer_top
  import kint_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_req,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [7:0]  token_length,
  output logic        length_clipped,
  output logic        last
);

  logic  accept;
  logic  push, pop, full, nonempty;
  step_t push_data, head;

  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  // Front: classifies each byte and forms its tokens.
  kint_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_req  (byte_req),
    .push      (push),
    .push_data (push_data)
  );

  // Queue of per-byte token entries.
  kint_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  // Back: hands out the tokens of each entry one transaction at a time.
  kint_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (nonempty),
    .q_data         (head),
    .q_pop          (pop),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .token_kind     (token_kind),
    .token_start    (token_start),
    .token_length   (token_length),
    .length_clipped (length_clipped),
    .last           (last)
  );

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import kint_pkg::*;

  // Predicts the tokens of the byte stream and checks the ones the block delivers.
  class lexer_scoreboard;
    typedef struct packed {
      kind_t       kind;
      logic [15:0] start;
      logic [7:0]  length;
      logic        clipped;
      logic        last;
    } token_rec_t;

    mode_t                 mode;
    logic [2:0]            progress;
    logic [POS_WIDTH-1:0]  token_pos;
    logic [POS_WIDTH-1:0]  offset;
    int unsigned           count;
    bit                    clip;
    token_rec_t            due_tokens[$];
    int                    failures;

    function new();
      mode = MODE_IDLE;
      progress = KW_NONE;
      token_pos = '0;
      offset = '0;
      count = 0;
      clip = 1'b0;
      failures = 0;
    endfunction

    function bit dropping();
      return mode == MODE_ERROR;
    endfunction

    function bit decimal(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit blank(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // KIND_EOI stands for a byte that is no operator.
    function kind_t operator_kind(logic [7:0] b);
      case (b)
        ";": return KIND_SEMI;
        "+": return KIND_PLUS;
        "-": return KIND_MINUS;
        "*": return KIND_TIMES;
        "/": return KIND_DIV;
        "(": return KIND_LPAREN;
        ")": return KIND_RPAREN;
        "{": return KIND_LBRACE;
        "}": return KIND_RBRACE;
        "=": return KIND_EQ;
        "<": return KIND_LT;
        ">": return KIND_GT;
        default: return KIND_EOI;
      endcase
    endfunction

    // The character that extends a keyword prefix.
    function logic [7:0] follow_char(logic [2:0] p);
      case (p)
        KW_D:    return "o";
        KW_I:    return "f";
        KW_W:    return "h";
        KW_WH:   return "i";
        KW_WHI:  return "l";
        KW_WHIL: return "e";
        default: return 8'h00;
      endcase
    endfunction

    // The keyword that the next matching character completes, if any.
    function kind_t keyword_kind(logic [2:0] p);
      case (p)
        KW_D:    return KIND_DO;
        KW_I:    return KIND_IF;
        KW_WHIL: return KIND_WHILE;
        default: return KIND_EOI;
      endcase
    endfunction

    function void emit(kind_t kind, logic [POS_WIDTH-1:0] pos, int unsigned len, bit clipped);
      token_rec_t t;
      t.kind = kind;
      t.start = 16'(pos);
      t.length = 8'(len);
      t.clipped = clipped;
      t.last = 1'b0;
      due_tokens.push_back(t);
    endfunction

    function void open_token(mode_t m, logic [POS_WIDTH-1:0] pos);
      mode = m;
      token_pos = pos;
      count = 1;
      clip = 1'b0;
    endfunction

    function void grow();
      if (count >= LEN_MAX) begin
        clip = 1'b1;
      end else begin
        count++;
      end
    endfunction

    // Handles a byte from the idle state.
    function void rescan(logic [7:0] b, logic [POS_WIDTH-1:0] here);
      kind_t k;
      k = operator_kind(b);
      mode = MODE_IDLE;
      if (b == 8'h00) begin
        offset = '0;
        emit(KIND_EOI, here, 1, 1'b0);
      end else if (blank(b)) begin
        return;
      end else if (k != KIND_EOI) begin
        emit(k, here, 1, 1'b0);
      end else if (b == "d" || b == "i" || b == "w") begin
        open_token(MODE_KEYWORD, here);
        progress = (b == "d") ? KW_D : (b == "i") ? KW_I : KW_W;
      end else if (alpha(b)) begin
        open_token(MODE_IDENT, here);
      end else if (decimal(b)) begin
        open_token(MODE_NUMBER, here);
      end else begin
        mode = MODE_ERROR;
        emit(KIND_ERROR, here, 1, 1'b0);
      end
    endfunction

    // Notes one accepted byte and queues the tokens it causes.
    function void note_byte(logic [7:0] b);
      logic [POS_WIDTH-1:0] here;
      int unsigned prior_size;
      here = offset;
      offset = here + 1'b1;
      prior_size = due_tokens.size();
      case (mode)
        MODE_ERROR: begin
          if (b == 8'h00) begin
            mode = MODE_IDLE;
            offset = '0;
          end
        end
        MODE_KEYWORD: begin
          if (b != 8'h00 && b == follow_char(progress)) begin
            if (keyword_kind(progress) != KIND_EOI) begin
              emit(keyword_kind(progress), token_pos, count + 1, 1'b0);
              mode = MODE_IDLE;
            end else begin
              progress = progress + 3'd1;
              grow();
            end
          end else if (alpha(b) || decimal(b)) begin
            mode = MODE_IDENT;
            grow();
          end else begin
            emit(KIND_IDENT, token_pos, count, clip);
            rescan(b, here);
          end
        end
        MODE_IDENT: begin
          if (alpha(b) || decimal(b)) begin
            grow();
          end else begin
            emit(KIND_IDENT, token_pos, count, clip);
            rescan(b, here);
          end
        end
        MODE_NUMBER: begin
          if (decimal(b)) begin
            grow();
          end else begin
            emit(KIND_NUMBER, token_pos, count, clip);
            rescan(b, here);
          end
        end
        default: rescan(b, here);
      endcase
      if (due_tokens.size() > prior_size) begin
        due_tokens[due_tokens.size() - 1].last = 1'b1;
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // Compares one delivered token with the oldest prediction.
    function void check_token(logic [4:0] kind, logic [15:0] start, logic [7:0] len,
                              logic clipped, logic last_flag);
      token_rec_t want;
      if (due_tokens.size() == 0) begin
        note_failure($sformatf({"unexpected token: kind %0d start %0d length %0d ",
                                "clipped %0b last %0b"},
                               kind, start, len, clipped, last_flag));
        return;
      end
      want = due_tokens.pop_front();
      if (kind !== want.kind || start !== want.start || len !== want.length ||
          clipped !== want.clipped || last_flag !== want.last) begin
        note_failure($sformatf({"token mismatch: expected kind %0d start %0d length %0d ",
                                "clipped %0b last %0b, got kind %0d start %0d length %0d ",
                                "clipped %0b last %0b"},
                               want.kind, want.start, want.length, want.clipped, want.last,
                               kind, start, len, clipped, last_flag));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  byte_req = 8'h00;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [7:0]  token_length;
  logic        length_clipped;
  logic        last;

  lexer_scoreboard sb = new();
  bit calm = 1'b0;
  int items_sent = 0;

  keyword_ident_number_tokenizer_top u_dut (
    .clk,
    .rst,
    .byte_valid,
    .byte_stall,
    .byte_req,
    .token_valid,
    .token_stall,
    .token_kind,
    .token_start,
    .token_length,
    .length_clipped,
    .last
  );

  always #4 clk = ~clk;

  // Idle stretches: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return rand_digit();
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'(9 + r);
  endfunction

  // Offers one byte, waits for the transaction and feeds the prediction.
  task automatic send_char(logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_req <= value;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (!sb.dropping()) items_sent++;
    sb.note_byte(value);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_word(logic [7:0] lead, int tail, bit numeric);
    send_char(lead);
    repeat (tail) send_char(numeric ? rand_digit() : rand_alnum());
  endtask

  // One random fragment of source text, mostly well formed.
  task automatic send_piece();
    int pick;
    string ops;
    ops = ";+-*/(){}=<>";
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 5))
        0: send_text("do");
        1: send_text("if");
        2: send_text("while");
        3: send_text("w");
        4: send_text("wh");
        default: send_text("whil");
      endcase
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) send_char(rand_alnum());
    end else if (pick < 35) begin
      send_word(rand_letter(), $urandom_range(0, 7), 1'b0);
    end else if (pick < 50) begin
      send_word(rand_digit(), $urandom_range(0, 5), 1'b1);
    end else if (pick < 72) begin
      send_char(ops[$urandom_range(0, 11)]);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 3)) send_char(rand_space());
    end else if (pick < 95) begin
      send_char(8'($urandom_range(1, 255)));
    end else begin
      send_char(8'h00);
    end
    // After an error the block drops bytes until a zero restarts it.
    if (sb.dropping()) begin
      repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(1, 255)));
      send_char(8'h00);
    end
  endtask

  // Token side: checks each transaction and stalls at random.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && token_valid && !token_stall) begin
        sb.check_token(token_kind, token_start, token_length, length_clipped, last);
      end
      if (calm) begin
        hold = 0;
      end else if (hold == 0) begin
        hold = pick_gap();
      end
      token_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // Byte side: directed text, long tokens, then random text.
  initial begin
    int drain;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_text("doif(x9)=while;");
    send_text("{dog+w7-i<42>}*/\t");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("Z");
    send_char(8'h00);
    send_text("whil");
    send_char(8'h00);

    // Lengths around the saturation point.
    send_word("q", 259, 1'b0);
    send_char(" ");
    send_word("5", 254, 1'b1);
    send_char(";");
    send_word("7", 255, 1'b1);
    send_char(" ");
    send_text("whi");
    send_word("8", 20, 1'b0);
    send_char(8'h00);

    while (items_sent < 1100) begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      send_piece();
    end
    send_char(8'h00);
    byte_valid <= 1'b0;
    calm = 1'b0;

    for (drain = 0; sb.due_tokens.size() != 0 && drain < 5000; drain++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.due_tokens.size() != 0) begin
      sb.note_failure($sformatf("%0d predicted tokens never arrived", sb.due_tokens.size()));
    end
    if (sb.failures == 0) begin
      $display("[keyword_ident_number_tokenizer_top] OK");
    end else begin
      $display("[keyword_ident_number_tokenizer_top] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("[keyword_ident_number_tokenizer_top] ERROR");
    $finish;
  end

endmodule

FILE: keyword_ident_number_tokenizer_top.f
rtl/kint_pkg.sv
rtl/kint_scan.sv
rtl/kint_queue.sv
rtl/kint_emit.sv
rtl/keyword_ident_number_tokenizer_top.sv
verif/tb_top.sv
